/* rtl/aus_pkg.sv */
package aus_pkg;

    // Default width of the setpoint, the limit register and the host value.
    localparam int DEF_SETPOINT_BITS = 12;

    // Request kinds carried in the mode field.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_ONOFF = 2'd2;

    // Hold counter: saturating tick count of a held up or down button.
    localparam int               HOLD_BITS = 6;
    localparam logic [HOLD_BITS-1:0] HOLD_MAX    = '1;
    localparam logic [HOLD_BITS-1:0] HOLD_MID    = 6'd20;
    localparam logic [HOLD_BITS-1:0] HOLD_COARSE = 6'd40;

    // Step sizes by hold count: fine below the thresholds above, mid and coarse past them.
    localparam int               STEP_BITS   = 5;
    localparam logic [STEP_BITS-1:0] STEP_FINE   = 5'd1;
    localparam logic [STEP_BITS-1:0] STEP_MID    = 5'd10;
    localparam logic [STEP_BITS-1:0] STEP_COARSE = 5'd20;

    // Panel state other than the setpoint itself.
    typedef struct packed {
        logic                 output_on;
        logic                 editor;
        logic                 menu_prev;
        logic                 onoff_prev;
        logic [HOLD_BITS-1:0] hold;
    } t_flags;

    // Control part of one request (the host value travels separately).
    typedef struct packed {
        logic [1:0] mode;
        logic       menu;
        logic       onoff;
        logic       up;
        logic       down;
        logic       release_ed;
    } t_req;

endpackage

/* rtl/aus_step.sv */
module aus_step #(
    parameter int SP_BITS = aus_pkg::DEF_SETPOINT_BITS
) (
    input  logic [SP_BITS-1:0] i_sp,
    input  aus_pkg::t_flags    i_flags,
    input  logic [SP_BITS-1:0] i_lim,
    input  aus_pkg::t_req      i_req,
    input  logic [SP_BITS-1:0] i_host,
    output logic [SP_BITS-1:0] o_sp,
    output aus_pkg::t_flags    o_flags,
    output logic               o_save
);

    logic               coarse;
    logic               fine;
    logic [SP_BITS-1:0] step;
    logic [SP_BITS:0]   sum;

    // Step size chosen from the hold count before this tick.
    always_comb begin
        coarse = i_flags.hold > aus_pkg::HOLD_MID;
        fine   = !coarse && i_flags.hold[0];
        if (i_flags.hold > aus_pkg::HOLD_COARSE) begin
            step = SP_BITS'(aus_pkg::STEP_COARSE);
        end else if (coarse) begin
            step = SP_BITS'(aus_pkg::STEP_MID);
        end else if (fine) begin
            step = SP_BITS'(aus_pkg::STEP_FINE);
        end else begin
            step = '0;
        end
        sum = {1'b0, i_sp} + {1'b0, step};
    end

    // Next state and save flag for one request.
    always_comb begin
        o_sp          = i_sp;
        o_flags       = i_flags;
        o_save        = 1'b0;
        o_flags.editor = i_flags.editor & ~i_req.release_ed;

        case (i_req.mode)
            aus_pkg::MODE_TICK: begin
                if (i_req.menu && !i_flags.menu_prev) begin
                    o_flags.editor = 1'b1;
                end
                o_flags.menu_prev = i_req.menu;

                // The panel buttons only act while the editor is closed.
                if (!o_flags.editor) begin
                    if (!i_req.onoff && i_flags.onoff_prev) begin
                        o_flags.output_on = ~i_flags.output_on;
                    end
                    o_flags.onoff_prev = i_req.onoff;

                    if (!i_req.down || !i_req.up) begin
                        if (i_flags.hold != aus_pkg::HOLD_MAX) begin
                            o_flags.hold = i_flags.hold + aus_pkg::HOLD_BITS'(1'b1);
                        end
                        if (!i_req.down) begin
                            // Down wins; a fine step at zero does nothing.
                            if (coarse || (fine && i_sp != '0)) begin
                                o_sp   = (i_sp >= step) ? i_sp - step : '0;
                                if (o_sp > i_lim) begin
                                    o_sp = i_lim;
                                end
                                o_save = 1'b1;
                            end
                        end else begin
                            // A fine step at or above the limit does nothing.
                            if (coarse || (fine && i_sp < i_lim)) begin
                                o_sp   = (sum <= {1'b0, i_lim}) ? sum[SP_BITS-1:0] : i_lim;
                                o_save = 1'b1;
                            end
                        end
                    end else begin
                        o_flags.hold = '0;
                    end
                end
            end
            aus_pkg::MODE_LOAD: begin
                if (i_host > i_lim) begin
                    o_sp   = i_lim;
                    o_save = 1'b1;
                end else begin
                    o_sp   = i_host;
                    o_save = i_host != i_sp;
                end
            end
            aus_pkg::MODE_ONOFF: begin
                o_flags.output_on = i_host[0];
            end
            default: begin
                // Unused request kind: state is only shown, apart from an editor release.
            end
        endcase
    end

endmodule

/* rtl/accelerated_updown_setpoint_unit.sv */
// Channel   Direction  Handshake                   Payload
// in        request    i_in_valid / o_in_stall     mode, levels, release, host value
// out       result     o_out_valid / i_out_stall   setpoint, output_on, editor, save
// cfg       write      i_cfg_we                    setpoint limit
//
// One request is taken every cycle while the result is not stalled; it passes through
// the input register, then into the result register together with the state update.
// The rate is set by the combinational update of the panel state.
// Reset is synchronous and active low; the limit returns to all ones.
// A stalled result holds the result register; the input register then fills
// and o_in_stall rises until the result is taken.
module accelerated_updown_setpoint_unit #(
    parameter int SETPOINT_BITS = aus_pkg::DEF_SETPOINT_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [SETPOINT_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_mode,
    input  logic                     i_menu_level,
    input  logic                     i_onoff_level,
    input  logic                     i_up_level,
    input  logic                     i_down_level,
    input  logic                     i_editor_release,
    input  logic [SETPOINT_BITS-1:0] i_host_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [SETPOINT_BITS-1:0] o_setpoint,
    output logic                     o_output_on,
    output logic                     o_editor_active,
    output logic                     o_save_request
);

    logic [SETPOINT_BITS-1:0] r_sp_limit;
    logic                     r_in_valid;
    aus_pkg::t_req            r_in_req;
    logic [SETPOINT_BITS-1:0] r_in_host;
    logic [SETPOINT_BITS-1:0] r_sp;
    aus_pkg::t_flags          r_flags;
    logic                     r_out_valid;
    logic [SETPOINT_BITS-1:0] r_out_sp;
    logic                     r_out_on;
    logic                     r_out_editor;
    logic                     r_out_save;
    logic [SETPOINT_BITS-1:0] n_sp;
    aus_pkg::t_flags          n_flags;
    logic                     n_save;
    logic                     out_free;
    logic                     advance;

    // Handshake: the input register moves on whenever the result slot frees.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_limit <= '1;
        end else if (i_cfg_we) begin
            r_sp_limit <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_req.mode       <= i_mode;
            r_in_req.menu       <= i_menu_level;
            r_in_req.onoff      <= i_onoff_level;
            r_in_req.up         <= i_up_level;
            r_in_req.down       <= i_down_level;
            r_in_req.release_ed <= i_editor_release;
            r_in_host           <= i_host_value;
        end
    end

    aus_step #(
        .SP_BITS (SETPOINT_BITS)
    ) u_step (
        .i_sp    (r_sp),
        .i_flags (r_flags),
        .i_lim   (r_sp_limit),
        .i_req   (r_in_req),
        .i_host  (r_in_host),
        .o_sp    (n_sp),
        .o_flags (n_flags),
        .o_save  (n_save)
    );

    // Panel state, updated as each request passes to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp               <= '0;
            r_flags.output_on  <= 1'b0;
            r_flags.editor     <= 1'b0;
            r_flags.menu_prev  <= 1'b1;
            r_flags.onoff_prev <= 1'b1;
            r_flags.hold       <= '0;
        end else if (advance) begin
            r_sp    <= n_sp;
            r_flags <= n_flags;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_sp     <= n_sp;
            r_out_on     <= n_flags.output_on;
            r_out_editor <= n_flags.editor;
            r_out_save   <= n_save;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_setpoint      = r_out_sp;
    assign o_output_on     = r_out_on;
    assign o_editor_active = r_out_editor;
    assign o_save_request  = r_out_save;

    // The input side only stalls behind a full, stalled result slot.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A host on/off request never asks for a save.
    a_onoff_nosave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_req.mode == aus_pkg::MODE_ONOFF) |=> !o_save_request)
        else $error("save raised by host on/off request");

    // A tick with no button held and the editor closed clears the hold count.
    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_req.mode == aus_pkg::MODE_TICK && r_in_req.up
         && r_in_req.down && !n_flags.editor) |=> (r_flags.hold == '0))
        else $error("hold count not cleared on release");

    // A release on a host request always closes the editor.
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_req.release_ed && r_in_req.mode != aus_pkg::MODE_TICK)
        |=> !r_flags.editor)
        else $error("editor still active after release");

endmodule
